/* rtl/core/owsm_pkg.sv */
// shared types, constants and coefficient helpers for the omni wheel speed mixer
package owsm_pkg;

    // default values for the top-level parameters
    localparam int DEF_FRAC_BITS    = 12;
    localparam int DEF_CORDIC_STEPS = 14;

    // field and datapath widths
    localparam int DATA_W = 16;
    localparam int CW     = 20;
    localparam int COEF_W = 16;
    localparam int PROD_W = CW + COEF_W;
    localparam int ACC_W  = PROD_W + 2;

    // reciprocal of the cordic gain, 32 fraction bits
    localparam longint KINV_Q32 = 64'sd2608131497;

    // product select codes, one per multiplier pass
    localparam logic [1:0] MUL_E33 = 2'd0;
    localparam logic [1:0] MUL_N58 = 2'd1;
    localparam logic [1:0] MUL_E67 = 2'd2;
    localparam logic [1:0] MUL_W33 = 2'd3;

    // input request
    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] vel_forward;
        logic signed [DATA_W-1:0] vel_sideways;
        logic signed [DATA_W-1:0] turn_rate;
    } t_in_item;

    // output request
    typedef struct packed {
        logic signed [DATA_W-1:0] wheel_one;
        logic signed [DATA_W-1:0] wheel_two;
        logic signed [DATA_W-1:0] wheel_three;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic       load_dir;
        logic       clear_dir;
        logic       cordic_step;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       sum_en;
        logic       store_en;
        logic       load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic func;
        logic lin_zero;
        logic cmd_zero;
    } t_dp_status;

    // matrix coefficient in hundredths, rounded to frac_bits fraction bits
    function automatic logic signed [COEF_W-1:0] coef_q(input int hundredths,
                                                        input int frac_bits);
        longint v;
        v = ((longint'(hundredths) <<< frac_bits) + 64'sd50) / 100;
        return COEF_W'(v);
    endfunction

    // start value of the rotation pass, gain compensated
    function automatic logic signed [CW-1:0] kinv_q(input int frac_bits);
        longint v;
        v = (KINV_Q32 + (64'sd1 <<< (31 - frac_bits))) >>> (32 - frac_bits);
        return CW'(v);
    endfunction

endpackage

/* rtl/core/owsm_ctrl.sv */
// sequencing state machine and handshake control for the omni wheel speed mixer
module owsm_ctrl
    import owsm_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int STEP_W       = $clog2(CORDIC_STEPS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd,
    output logic [STEP_W-1:0] o_step
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CORDIC = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_pending, n_pending;
    logic              r_out_valid, n_out_valid;
    logic              w_accept;

    // take a request only when idle, out of reset and the output slot can take a result
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_step      = r_cnt;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pending   = r_pending;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_status.func) begin
                        if (r_pending) begin
                            o_cmd.load_out = 1'b1;
                            n_out_valid    = 1'b1;
                            n_pending      = 1'b0;
                        end
                    end else if (i_status.cmd_zero) begin
                        n_pending = 1'b0;
                    end else if (i_status.lin_zero) begin
                        o_cmd.clear_dir = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_MUL;
                    end else begin
                        o_cmd.load_dir = 1'b1;
                        n_cnt          = '0;
                        n_state        = S_CORDIC;
                    end
                end
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (r_cnt == STEP_LAST) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end else begin
                    n_cnt = STEP_W'(r_cnt + 1'b1);
                end
            end
            S_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_cnt[1:0];
                if (r_cnt[1:0] == MUL_W33) begin
                    n_cnt   = '0;
                    n_state = S_SUM;
                end else begin
                    n_cnt = STEP_W'(r_cnt + 1'b1);
                end
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                o_cmd.store_en = 1'b1;
                n_pending      = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // requests are taken only while idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    // a result is only loaded from pending speeds
    a_load_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> r_pending)
        else $error("result loaded without pending speeds");

    // finishing a command leaves speeds pending
    a_fin_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_pending && r_state == S_IDLE))
        else $error("command finished without pending speeds");

    // cordic step index stays in range
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) |-> (r_cnt <= STEP_LAST))
        else $error("cordic step out of range");

    // a result leaves only when the receiver takes it
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(i_out_ready))
        else $error("result dropped without acceptance");
`endif

endmodule

/* rtl/core/owsm_dpath.sv */
// cordic normalizer, coefficient multiplier and speed registers of the omni wheel speed mixer
module owsm_dpath
    import owsm_pkg::*;
#(
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int STEP_W       = $clog2(CORDIC_STEPS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_in_data,
    input  t_dp_cmd           i_cmd,
    input  logic [STEP_W-1:0] i_step,
    output t_dp_status        o_status,
    output t_out_item         o_out_data
);

    localparam logic signed [COEF_W-1:0] C33  = coef_q(33, FRAC_BITS);
    localparam logic signed [COEF_W-1:0] C58  = coef_q(58, FRAC_BITS);
    localparam logic signed [COEF_W-1:0] C67  = coef_q(67, FRAC_BITS);
    localparam logic signed [CW-1:0]     KINV = kinv_q(FRAC_BITS);
    localparam logic signed [ACC_W-1:0]  HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0]  SAT_LO = -ACC_W'(32768);

    logic signed [CW-1:0]     r_x, r_y, r_c, r_s, r_turn;
    logic                     r_flip;
    logic signed [PROD_W-1:0] r_prod [4];
    logic signed [ACC_W-1:0]  r_acc1, r_acc2, r_acc3;
    logic signed [DATA_W-1:0] r_speed1, r_speed2, r_speed3;
    t_out_item                r_out;

    logic signed [CW-1:0]     w_side, w_fwd;
    logic                     w_neg, w_cw;
    logic signed [CW-1:0]     w_xs, w_ys, w_cs, w_ss;
    logic signed [CW-1:0]     w_east, w_north, w_opa;
    logic signed [COEF_W-1:0] w_opb;
    logic signed [ACC_W-1:0]  w_p33e, w_p58n, w_p67e, w_p33w;

    // status from the incoming request
    assign o_status.func     = i_in_data.func;
    assign o_status.lin_zero = (i_in_data.vel_forward == '0) && (i_in_data.vel_sideways == '0);
    assign o_status.cmd_zero = o_status.lin_zero && (i_in_data.turn_rate == '0);

    // fold the linear vector into the right half plane
    assign w_side = CW'(i_in_data.vel_sideways);
    assign w_fwd  = CW'(i_in_data.vel_forward);
    assign w_neg  = i_in_data.vel_sideways[DATA_W-1];

    // one step of vectoring and rotation, sharing the direction decision
    assign w_cw = !r_y[CW-1];
    assign w_xs = r_x >>> i_step;
    assign w_ys = r_y >>> i_step;
    assign w_cs = r_c >>> i_step;
    assign w_ss = r_s >>> i_step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_dir) begin
            r_x    <= w_neg ? -w_side : w_side;
            r_y    <= w_neg ? -w_fwd : w_fwd;
            r_c    <= KINV;
            r_s    <= '0;
            r_flip <= w_neg;
            r_turn <= CW'(i_in_data.turn_rate);
        end else if (i_cmd.clear_dir) begin
            r_c    <= '0;
            r_s    <= '0;
            r_flip <= 1'b0;
            r_turn <= CW'(i_in_data.turn_rate);
        end else if (i_cmd.cordic_step) begin
            if (w_cw) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_c <= r_c - w_ss;
                r_s <= r_s + w_cs;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_c <= r_c + w_ss;
                r_s <= r_s - w_cs;
            end
        end
    end

    // unit direction with the half-plane fold undone
    assign w_east  = r_flip ? -r_c : r_c;
    assign w_north = r_flip ? -r_s : r_s;

    // operand select for the shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_E33: begin
                w_opa = w_east;
                w_opb = C33;
            end
            MUL_N58: begin
                w_opa = w_north;
                w_opb = C58;
            end
            MUL_E67: begin
                w_opa = w_east;
                w_opb = C67;
            end
            MUL_W33: begin
                w_opa = r_turn;
                w_opb = C33;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // one product per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod[i_cmd.mul_sel] <= PROD_W'(w_opa * w_opb);
        end
    end

    // matrix row sums
    assign w_p33e = ACC_W'(r_prod[MUL_E33]);
    assign w_p58n = ACC_W'(r_prod[MUL_N58]);
    assign w_p67e = ACC_W'(r_prod[MUL_E67]);
    assign w_p33w = ACC_W'(r_prod[MUL_W33]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_acc1 <= w_p33w - w_p33e + w_p58n;
            r_acc2 <= w_p33w - w_p33e - w_p58n;
            r_acc3 <= w_p33w + w_p67e;
        end
    end

    // round to the output scale and clamp
    function automatic logic signed [DATA_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        v = (acc + HALF) >>> FRAC_BITS;
        if (v > SAT_HI) begin
            return 16'sh7fff;
        end else if (v < SAT_LO) begin
            return 16'sh8000;
        end
        return DATA_W'(v);
    endfunction

    // stored speeds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed1 <= '0;
            r_speed2 <= '0;
            r_speed3 <= '0;
        end else if (i_cmd.store_en) begin
            r_speed1 <= finish(r_acc1);
            r_speed2 <= finish(r_acc2);
            r_speed3 <= finish(r_acc3);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.wheel_one   <= r_speed1;
            r_out.wheel_two   <= r_speed2;
            r_out.wheel_three <= r_speed3;
        end
    end

    assign o_out_data = r_out;

endmodule

/* rtl/core/omni_wheel_speed_mixer.sv */
// top level of the omni wheel speed mixer
//
// Inverse kinematics for a three-wheel omni base. The input channel
// (i_in_valid / o_in_ready / i_in_data) takes two kinds of request: a
// velocity command (func = 0) or a publish tick (func = 1). A nonzero
// command normalizes the linear velocity to a unit direction with an
// iterative CORDIC, multiplies (east, north, turn) by the fixed mixing
// matrix and stores three saturated wheel speeds as pending. An all-zero
// command only clears pending. A tick while pending sends the stored
// speeds on the output channel (o_out_valid / i_out_ready / o_out_data).
// A command runs one CORDIC step per cycle, then four passes through the
// shared multiplier, a sum and a rounding step; a pure rotation skips
// the CORDIC. No request is taken until a command is finished. A tick's
// result appears on the output in the cycle after acceptance.
// A waiting result sits in the output register; while the receiver stalls
// no request is taken, so the input is held off until the slot is freed.
// Synchronous reset clears pending, the stored speeds and the output valid.
module omni_wheel_speed_mixer
    import owsm_pkg::*;
#(
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    t_dp_cmd           w_cmd;
    t_dp_status        w_status;
    logic [STEP_W-1:0] w_step;

    // sequencing and handshake control
    owsm_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .STEP_W       (STEP_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_step      (w_step)
    );

    // arithmetic and storage
    owsm_dpath #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS),
        .STEP_W       (STEP_W)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .i_step     (w_step),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

endmodule
